// ===== rtl/core/aging_peer_table_unit_macros.svh =====
// Assertion helpers for the aging peer table.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef AGING_PEER_TABLE_UNIT_MACROS_SVH
`define AGING_PEER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication
`define APT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/apt_pkg.sv =====
`default_nettype none

package apt_pkg;

  // Build defaults
  localparam int unsigned NUM_SLOTS_DEF = 16;

  // Register indexes
  localparam int unsigned CFG_IDX_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 4'd1;

  // Register reset values
  localparam logic [31:0] TIMEOUT_RST = 32'd30;
  localparam logic        WRAP_RST    = 1'b0;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_PRUNE  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_PRUNED    = 3'd5;

  // Command word
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] peer_addr;
    logic [31:0] now;
  } apt_req_t;

  // Result word
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [4:0] removed_cnt;
  } apt_rsp_t;

  // Configuration registers
  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic        wrap_mode;
  } apt_cfg_t;

  // One stored slot
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] seen_at;
  } apt_entry_t;

  // Per-slot compare outcome
  typedef struct packed {
    logic hit;
    logic expired;
  } apt_cmp_t;

endpackage

`default_nettype wire

// ===== rtl/core/apt_ram.sv =====
`default_nettype none

// Simple dual-port RAM, registered read
module apt_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/apt_slot_cmp.sv =====
`default_nettype none

// Shared slot comparator: key match and age check for the slot being scanned
module apt_slot_cmp (
  input  wire apt_pkg::apt_entry_t entry_i,
  input  wire logic [31:0]         key_i,
  input  wire logic [31:0]         now_i,
  input  wire apt_pkg::apt_cfg_t   cfg_i,
  output apt_pkg::apt_cmp_t        res_o
);

  logic [31:0] age;
  logic        backward;

  // Modular age; a backward clock expires the slot unless wrapping is on
  assign age      = now_i - entry_i.seen_at;
  assign backward = now_i < entry_i.seen_at;

  assign res_o.hit     = entry_i.addr == key_i;
  assign res_o.expired = (backward && !cfg_i.wrap_mode) || (age > cfg_i.timeout_ticks);

endmodule

`default_nettype wire

// ===== rtl/core/apt_seq.sv =====
`default_nettype none

// Command sequencer: valid bits, slot scan and result build
module apt_seq #(
  parameter int unsigned NUM_SLOTS = apt_pkg::NUM_SLOTS_DEF,
  parameter int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  parameter int unsigned CNT_W     = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire apt_pkg::apt_req_t   req_i,
  output logic                     done_o,
  output apt_pkg::apt_rsp_t        rsp_o,
  output apt_pkg::apt_req_t        op_o,
  input  wire apt_pkg::apt_cmp_t   cmp_i,
  output logic                     rd_en_o,
  output logic [IDX_W-1:0]         rd_addr_o,
  output logic                     wr_en_o,
  output logic [IDX_W-1:0]         wr_addr_o,
  output apt_pkg::apt_entry_t      wr_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_q;
  apt_pkg::apt_req_t  op_q;
  logic [CNT_W-1:0]   issue_cnt_q;
  logic               cmp_vld_q;
  logic               cmp_last_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               hit_found_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [CNT_W-1:0]   prune_cnt_q;
  logic [NUM_SLOTS-1:0] valid_q;
  logic               done_q;
  apt_pkg::apt_rsp_t  rsp_q;

  logic               issuing;
  logic               slot_v;
  logic               do_add;
  logic [31:0]        hit_idx_ext;
  logic [31:0]        free_idx_ext;
  logic [31:0]        cnt_ext;
  apt_pkg::apt_rsp_t  fin_rsp;

  assign issuing = issue_cnt_q < CNT_W'(NUM_SLOTS);
  assign slot_v  = valid_q[cmp_idx_q];

  // Result fields widened to 32 bits, then sliced to port widths
  assign hit_idx_ext  = 32'(hit_idx_q);
  assign free_idx_ext = 32'(free_idx_q);
  assign cnt_ext      = 32'(prune_cnt_q);

  // RAM access: one read per scan cycle while issuing, one write at the end of an add that finds a slot
  assign rd_en_o   = (state_q == S_SCAN) && issuing;
  assign rd_addr_o = issue_cnt_q[IDX_W-1:0];
  assign do_add    = (state_q == S_DONE) && (op_q.cmd == apt_pkg::CMD_ADD);
  assign wr_en_o   = do_add && (hit_found_q || free_found_q);
  assign wr_addr_o = hit_found_q ? hit_idx_q : free_idx_q;
  assign wr_data_o = '{addr: op_q.peer_addr, seen_at: op_q.now};

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign op_o   = op_q;

  // Result word once the scan is over
  always_comb begin
    fin_rsp = '{status: apt_pkg::ST_NOT_FOUND, slot_index: 4'd0, removed_cnt: 5'd0};
    unique case (op_q.cmd)
      apt_pkg::CMD_ADD: begin
        if (hit_found_q) begin
          fin_rsp.status     = apt_pkg::ST_UPDATED;
          fin_rsp.slot_index = hit_idx_ext[3:0];
        end else if (free_found_q) begin
          fin_rsp.status     = apt_pkg::ST_ADDED;
          fin_rsp.slot_index = free_idx_ext[3:0];
        end else begin
          fin_rsp.status = apt_pkg::ST_FULL;
        end
      end
      apt_pkg::CMD_PRUNE: begin
        fin_rsp.status      = apt_pkg::ST_PRUNED;
        fin_rsp.removed_cnt = cnt_ext[4:0];
      end
      apt_pkg::CMD_LOOKUP: begin
        if (hit_found_q) begin
          fin_rsp.status     = apt_pkg::ST_FOUND;
          fin_rsp.slot_index = hit_idx_ext[3:0];
        end
      end
      default: begin
        fin_rsp.status = apt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // State, scan bookkeeping and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      valid_q      <= '0;
      done_q       <= 1'b0;
      rsp_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      cmp_idx_q    <= '0;
      issue_cnt_q  <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      prune_cnt_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= start && (req_i.cmd == apt_pkg::CMD_NONE);
          if (start) begin
            op_q         <= req_i;
            issue_cnt_q  <= '0;
            cmp_vld_q    <= 1'b0;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            prune_cnt_q  <= '0;
            if (req_i.cmd == apt_pkg::CMD_NONE) begin
              // unused command answers at once
              rsp_q  <= '{status: apt_pkg::ST_NOT_FOUND, slot_index: 4'd0,
                          removed_cnt: 5'd0};
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          done_q     <= 1'b0;
          // read issue runs one slot ahead of the compare
          cmp_vld_q  <= issuing;
          cmp_idx_q  <= issue_cnt_q[IDX_W-1:0];
          cmp_last_q <= issue_cnt_q == CNT_W'(NUM_SLOTS - 1);
          if (issuing) begin
            issue_cnt_q <= issue_cnt_q + 1'b1;
          end
          if (cmp_vld_q) begin
            if (op_q.cmd == apt_pkg::CMD_PRUNE) begin
              if (slot_v && cmp_i.expired) begin
                valid_q[cmp_idx_q] <= 1'b0;
                prune_cnt_q        <= prune_cnt_q + 1'b1;
              end
            end else begin
              // keep the lowest matching and lowest free slot
              if (slot_v && cmp_i.hit && !hit_found_q) begin
                hit_found_q <= 1'b1;
                hit_idx_q   <= cmp_idx_q;
              end
              if (!slot_v && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= cmp_idx_q;
              end
            end
            if (cmp_last_q) begin
              state_q <= S_DONE;
            end
          end
        end

        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          rsp_q   <= fin_rsp;
          // new peer takes the lowest free slot
          if ((op_q.cmd == apt_pkg::CMD_ADD) && !hit_found_q && free_found_q) begin
            valid_q[free_idx_q] <= 1'b1;
          end
        end

        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/aging_peer_table_unit.sv =====
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+----------------------------------
// command  | in        | start && !busy            | req_i  : cmd, peer_addr, now
// result   | out       | done_o, one cycle strobe  | rsp_o  : status, slot_index, removed
// config   | in        | cfg_valid_i && cfg_ready_o| cfg_index_i, cfg_data_i
//
// Add, prune and lookup scan every slot through the single RAM read port, one slot
// per cycle: busy stays high through the scan and the done state, and the result strobe
// comes in the first cycle with busy low, in which a new command can already be taken.
// The unused command answers in the cycle after it is taken and leaves busy low.
// Reset clears the valid flip-flops and the registers; slot contents are not cleared.
// Results cannot be held off; cfg_ready_o is always high.
`default_nettype none

`include "aging_peer_table_unit_macros.svh"

module aging_peer_table_unit #(
  parameter int unsigned NUM_SLOTS = apt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire apt_pkg::apt_req_t              req_i,
  output logic                                done_o,
  output apt_pkg::apt_rsp_t                   rsp_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [apt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);

  apt_pkg::apt_cfg_t   cfg_q;
  apt_pkg::apt_req_t   op;
  apt_pkg::apt_cmp_t   cmp_res;
  apt_pkg::apt_entry_t rd_entry;
  apt_pkg::apt_entry_t wr_entry;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                cmd_take;
  logic                cmd_unused;
  logic                quick_ans;
  logic                rsp_other;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{timeout_ticks: apt_pkg::TIMEOUT_RST, wrap_mode: apt_pkg::WRAP_RST};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        apt_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data_i;
        apt_pkg::CFG_WRAP:    cfg_q.wrap_mode     <= cfg_data_i[0];
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // Sequencer
  apt_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .op_o      (op),
    .cmp_i     (cmp_res),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_entry)
  );

  // Slot store: address key and last-seen time per slot
  apt_ram #(
    .WIDTH  ($bits(apt_pkg::apt_entry_t)),
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  // Shared comparator on the slot just read
  apt_slot_cmp u_cmp (
    .entry_i (rd_entry),
    .key_i   (op.peer_addr),
    .now_i   (op.now),
    .cfg_i   (cfg_q),
    .res_o   (cmp_res)
  );

  // Checks
  assign cmd_take   = start && !busy;
  assign cmd_unused = req_i.cmd == apt_pkg::CMD_NONE;
  assign quick_ans  = done_o && !busy && (rsp_o.status == apt_pkg::ST_NOT_FOUND);
  assign rsp_other  = done_o && (rsp_o.status != apt_pkg::ST_PRUNED);

  `APT_ASSERT_NEXT(a_scan_starts, cmd_take && !cmd_unused, busy && !done_o, "scan not started")
  `APT_ASSERT_NEXT(a_unused_quick, cmd_take && cmd_unused, quick_ans, "unused command late")
  `APT_ASSERT_NOW(a_count_only_prune, rsp_other, rsp_o.removed_cnt == 5'd0, "stray count")
  `APT_ASSERT_NOW(a_no_write_idle, !busy, !wr_en && !rd_en, "slot store accessed while idle")

endmodule

`default_nettype wire
